[rtl/ata_pkg.sv]
// shared types, constants and the squared-cosine table for the tilt angle block
// no dependencies
`default_nettype none
package ata_pkg;

  typedef struct packed {
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_low_byte;
    logic [7:0] z_high_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] angle_x;
    logic [7:0] angle_z;
    logic       zero_vector;
  } out_t;

  // binary search over 0..90 takes seven steps
  localparam int unsigned STEPS   = 7;
  localparam logic [6:0]  TAB_LEN = 7'd90;
  localparam int unsigned KW      = 31;

  typedef logic [KW-1:0] k_tab_t [0:90];

  // k[d] = floor(c[d]^2 / 2^30), c being the q30 cosine of d degrees
  function automatic k_tab_t build_k();
    longint c [0:90];
    k_tab_t k;
    c[0] = 64'sd1073741824;
    c[1] = 64'sd1073578288;
    for (int n = 1; n <= 88; n++) begin
      c[n+1] = ((64'sd2147156576 * c[n] + 64'sd536870912) >>> 30) - c[n-1];
    end
    c[45] = 64'sd759250125;
    c[90] = 64'sd0;
    for (int n = 0; n <= 90; n++) begin
      k[n] = KW'((c[n] * c[n]) >>> 30);
    end
    return k;
  endfunction

  localparam k_tab_t K_TAB = build_k();

endpackage
`default_nettype wire

[rtl/accel_tilt_angle.sv]
// top level of the accelerometer tilt angle pipeline
// depends on ata_pkg and ata_search
`default_nettype none
// Takes one raw six-byte sample per clock and returns the tilt of the X and
// Z axes against the measured vector, in whole degrees 0..180 truncated.
// busy is always low: a new beat may start every cycle. Each result appears
// on res_o for one cycle with valid_o high; the receiver cannot stall, so
// results must be taken as they come. The pipeline runs through the
// unpack/square stage, the sum stage, seven binary search stages over the
// 91-entry squared-cosine table (one multiply and compare per stage) and
// the output register. An all-zero sample sets zero_vector and gives both
// angles as 0.
module accel_tilt_angle #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ata_pkg::in_t  in_i,
  output logic               valid_o,
  output ata_pkg::out_t      res_o
);
  import ata_pkg::*;

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned SQW = 2 * SB - 1;
  localparam int unsigned SW  = 2 * SB;
  localparam int unsigned LAT = STEPS + 3;

  // unpack one axis: top bits from the msb byte, rest from the lsb byte top
  function automatic logic signed [SB-1:0] unpack(logic [7:0] lo, logic [7:0] hi);
    logic [15:0] w;
    w = {hi, lo} >> (16 - SB);
    return w[SB-1:0];
  endfunction

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // stage 1: unpacked samples squared
  logic signed [SB-1:0] x_v, y_v, z_v;
  logic [SQW-1:0] sqx_q, sqy_q, sqz_q;
  logic           negx_q, negz_q, zx_q, zz_q;

  always_comb begin
    x_v = unpack(in_i.x_low_byte, in_i.x_high_byte);
    y_v = unpack(in_i.y_low_byte, in_i.y_high_byte);
    z_v = unpack(in_i.z_low_byte, in_i.z_high_byte);
  end

  // operands sign-extended to the square width before the multiply
  always_ff @(posedge clk_i) begin
    sqx_q  <= SQW'(SQW'(x_v) * SQW'(x_v));
    sqy_q  <= SQW'(SQW'(y_v) * SQW'(y_v));
    sqz_q  <= SQW'(SQW'(z_v) * SQW'(z_v));
    negx_q <= x_v[SB-1];
    negz_q <= z_v[SB-1];
    zx_q   <= (x_v == '0);
    zz_q   <= (z_v == '0);
  end

  // stage 2: squared magnitude
  logic [SW-1:0]  s_q;
  logic [SQW-1:0] sqx2_q, sqz2_q;
  logic           negx2_q, negz2_q, zx2_q, zz2_q;

  always_ff @(posedge clk_i) begin
    s_q     <= SW'(sqx_q) + SW'(sqy_q) + SW'(sqz_q);
    sqx2_q  <= sqx_q;
    sqz2_q  <= sqz_q;
    negx2_q <= negx_q;
    negz2_q <= negz_q;
    zx2_q   <= zx_q;
    zz2_q   <= zz_q;
  end

  // search stages, one per axis
  logic [7:0] ang_x, ang_z;

  ata_search #(.SAMPLE_BITS(SB)) u_search_x (
    .clk_i   (clk_i),
    .sq_i    (sqx2_q),
    .s_i     (s_q),
    .neg_i   (negx2_q),
    .zero_i  (zx2_q),
    .angle_o (ang_x)
  );

  ata_search #(.SAMPLE_BITS(SB)) u_search_z (
    .clk_i   (clk_i),
    .sq_i    (sqz2_q),
    .s_i     (s_q),
    .neg_i   (negz2_q),
    .zero_i  (zz2_q),
    .angle_o (ang_z)
  );

  // zero-vector flag follows the search
  logic zv_q [0:STEPS-1];

  always_ff @(posedge clk_i) begin
    zv_q[0] <= (s_q == '0);
    for (int i = 1; i < STEPS; i++) begin
      zv_q[i] <= zv_q[i-1];
    end
  end

  // valid bits travel beside the data, one per stage
  logic [LAT-1:0] vld_q, vld_d;

  assign vld_d = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // output register
  out_t res_q, res_d;

  always_comb begin
    res_d.zero_vector = zv_q[STEPS-1];
    res_d.angle_x     = zv_q[STEPS-1] ? 8'd0 : ang_x;
    res_d.angle_z     = zv_q[STEPS-1] ? 8'd0 : ang_z;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = vld_q[LAT-1];
  assign res_o   = res_q;

`ifndef SYNTH
  a_zero_angles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.zero_vector |-> res_o.angle_x == 8'd0 && res_o.angle_z == 8'd0)
    else $error("zero vector with nonzero angle");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.angle_x <= 8'd180 && res_o.angle_z <= 8'd180)
    else $error("angle out of range");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("result missing after start");
`endif

endmodule
`default_nettype wire

[rtl/ata_search.sv]
// pipelined binary search of one axis angle against the squared-cosine table
// depends on ata_pkg
`default_nettype none
module ata_search #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic [2*SAMPLE_BITS-2:0]   sq_i,
  input  wire logic [2*SAMPLE_BITS-1:0]   s_i,
  input  wire logic                       neg_i,
  input  wire logic                       zero_i,
  output logic      [7:0]                 angle_o
);
  import ata_pkg::*;

  localparam int unsigned SQW = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SW  = 2 * SAMPLE_BITS;
  localparam int unsigned PW  = KW + SW;

  logic [6:0]     n_s    [0:STEPS];
  logic [SQW-1:0] sq_s   [0:STEPS];
  logic [SW-1:0]  s_s    [0:STEPS];
  logic           neg_s  [0:STEPS];
  logic           zero_s [0:STEPS];

  assign n_s[0]    = '0;
  assign sq_s[0]   = sq_i;
  assign s_s[0]    = s_i;
  assign neg_s[0]  = neg_i;
  assign zero_s[0] = zero_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [6:0] Bit = 7'(1 << (STEPS - 1 - i));
    logic [6:0]    cand;
    logic [6:0]    idx;
    logic          in_rng;
    logic [PW-1:0] prod;
    logic [PW-1:0] lhs;
    logic          pass;
    logic [6:0]    n_d;

    always_comb begin
      cand   = n_s[i] + Bit;
      in_rng = (cand <= TAB_LEN);
      // positive axis tests k[cand], negative axis tests k[cand-1]
      idx    = in_rng ? (neg_s[i] ? cand - 7'd1 : cand) : 7'd0;
      prod   = PW'(K_TAB[idx]) * PW'(s_s[i]);
      lhs    = PW'({sq_s[i], 30'b0});
      pass   = neg_s[i] ? (lhs < prod) : (lhs <= prod);
      n_d    = (in_rng && pass) ? cand : n_s[i];
    end

    always_ff @(posedge clk_i) begin
      n_s[i+1]    <= n_d;
      sq_s[i+1]   <= sq_s[i];
      s_s[i+1]    <= s_s[i];
      neg_s[i+1]  <= neg_s[i];
      zero_s[i+1] <= zero_s[i];
    end
  end

  always_comb begin
    if (zero_s[STEPS]) begin
      angle_o = 8'd90;
    end else if (neg_s[STEPS]) begin
      angle_o = 8'd180 - {1'b0, n_s[STEPS]};
    end else begin
      angle_o = {1'b0, n_s[STEPS]};
    end
  end

endmodule
`default_nettype wire

[sim/tb_accel_tilt_angle.sv]
// self-checking testbench for the accelerometer tilt angle block
// depends on ata_pkg and accel_tilt_angle from the rtl folder
`timescale 1ns / 100ps
`default_nettype none
module tb_accel_tilt_angle;
  import ata_pkg::*;

  localparam int unsigned SB = 10;
  // cycles still waited once the expected-result queue has emptied
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic valid_o;
  out_t res_o;

  accel_tilt_angle #(
    .SAMPLE_BITS(SB)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  // q30 cosine of each whole degree, built once at the start
  longint cos_q30 [0:180];
  // expected results in order of acceptance
  out_t   tilt_expect_q [$];
  int     err_count;
  bit     idle_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void build_cos_table();
    longint p;
    cos_q30[0] = 64'sd1073741824;
    cos_q30[1] = 64'sd1073578288;
    for (int n = 1; n <= 88; n++) begin
      p = 64'sd2147156576 * cos_q30[n] + 64'sd536870912;
      cos_q30[n+1] = (p >>> 30) - cos_q30[n-1];
    end
    cos_q30[45] = 64'sd759250125;
    cos_q30[90] = 64'sd0;
    for (int n = 91; n <= 180; n++) begin
      cos_q30[n] = -cos_q30[180-n];
    end
  endfunction

  // raw register pair to a sign-extended sample
  function automatic int axis_value(logic [7:0] lo, logic [7:0] hi);
    int unsigned raw;
    raw = ((int'(hi)) << (SB - 8)) | (int'(lo) >> (16 - SB));
    raw = raw & ((1 << SB) - 1);
    if (raw & (1 << (SB - 1))) begin
      return int'(raw) - (1 << SB);
    end
    return int'(raw);
  endfunction

  // largest degree whose cosine bound still holds against a^2 / s
  function automatic logic [7:0] tilt_deg(int a, longint unsigned s);
    longint unsigned lhs;
    longint unsigned mag;
    longint unsigned rhs;
    bit              ok;
    int              ang;
    lhs = longint'(a * a) << 30;
    ang = 0;
    for (int d = 1; d <= 180; d++) begin
      mag = (cos_q30[d] < 0) ? -cos_q30[d] : cos_q30[d];
      rhs = ((mag * mag) >> 30) * s;
      if (cos_q30[d] >= 0) begin
        ok = (a <= 0) || (lhs <= rhs);
      end else begin
        ok = (a < 0) && (lhs >= rhs);
      end
      if (!ok) break;
      ang = d;
    end
    return 8'(ang);
  endfunction

  function automatic out_t predict_tilt(in_t b);
    int              x;
    int              y;
    int              z;
    longint unsigned s;
    out_t            r;
    x = axis_value(b.x_low_byte, b.x_high_byte);
    y = axis_value(b.y_low_byte, b.y_high_byte);
    z = axis_value(b.z_low_byte, b.z_high_byte);
    s = longint'(x * x) + longint'(y * y) + longint'(z * z);
    r = '0;
    if (s == 0) begin
      r.zero_vector = 1'b1;
    end else begin
      r.angle_x = tilt_deg(x, s);
      r.angle_z = tilt_deg(z, s);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker: valid_o is a one-cycle strobe, sampled at the edge ending it
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && valid_o) begin
      if (tilt_expect_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = tilt_expect_q.pop_front();
        if (res_o.angle_x !== want.angle_x)
          report_mismatch("angle_x", res_o.angle_x, want.angle_x);
        if (res_o.angle_z !== want.angle_z)
          report_mismatch("angle_z", res_o.angle_z, want.angle_z);
        if (res_o.zero_vector !== want.zero_vector)
          report_mismatch("zero_vector", res_o.zero_vector, want.zero_vector);
      end
    end
  end

  // drive one beat and hold it until accepted; start stays high afterwards
  task automatic send_sample(in_t b);
    start <= 1'b1;
    in_i  <= b;
    do @(posedge clk_i); while (busy);
    tilt_expect_q.push_back(predict_tilt(b));
  endtask

  // random gap between beats, start low for the whole burst
  task automatic maybe_idle();
    if (idle_on && ($urandom_range(0, 3) == 0)) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  function automatic in_t pack_axes(int x, int y, int z, logic [5:0] junk);
    in_t b;
    logic [SB-1:0] rx;
    logic [SB-1:0] ry;
    logic [SB-1:0] rz;
    rx = SB'(x);
    ry = SB'(y);
    rz = SB'(z);
    b.x_high_byte = rx[SB-1 -: 8];
    b.y_high_byte = ry[SB-1 -: 8];
    b.z_high_byte = rz[SB-1 -: 8];
    // unused low bits carry junk so they are exercised
    b.x_low_byte = {rx[1:0], junk};
    b.y_low_byte = {ry[1:0], ~junk};
    b.z_low_byte = {rz[1:0], junk ^ 6'h2a};
    return b;
  endfunction

  task automatic test_directed();
    int v [0:24][0:2] = '{
      '{0, 0, 0}, '{511, 0, 0}, '{-512, 0, 0}, '{0, 0, 511}, '{0, 0, -512},
      '{0, 511, 0}, '{0, -512, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 0, -1},
      '{1, 1, 0}, '{-1, 0, 1}, '{100, 0, 100}, '{-100, 0, -100},
      '{511, 511, 511}, '{-512, -512, -512}, '{511, -512, 511},
      '{-512, 511, -512}, '{3, 4, 0}, '{0, 3, 4}, '{1, 511, 1},
      '{-1, -512, -1}, '{300, 200, -100}, '{0, 1, 0}, '{2, 0, -2}
    };
    for (int i = 0; i < 25; i++) begin
      send_sample(pack_axes(v[i][0], v[i][1], v[i][2], 6'(i * 11)));
      maybe_idle();
    end
    // every unused low-byte bit set on a zero sample: still the zero vector
    send_sample('{x_low_byte: 8'h3f, x_high_byte: 8'h00, y_low_byte: 8'h3f,
                  y_high_byte: 8'h00, z_low_byte: 8'h3f, z_high_byte: 8'h00});
  endtask

  function automatic int rand_axis();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 4) - 2;
      1: return $urandom_range(0, 40) - 20;
      2: return ($urandom_range(0, 1)) ? 511 : -512;
      3: return 0;
      default: return $urandom_range(0, 1023) - 512;
    endcase
  endfunction

  task automatic test_random(int count);
    in_t b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        b = in_t'(48'({$urandom(), $urandom()}));
      end else begin
        b = pack_axes(rand_axis(), rand_axis(), rand_axis(), 6'($urandom()));
      end
      send_sample(b);
      maybe_idle();
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    test_random(count);
    start <= 1'b0;
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    while (tilt_expect_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tilt_expect_q.size() != 0)
      report_mismatch("results still outstanding", 0, tilt_expect_q.size());
  endtask

  initial begin
    err_count = 0;
    idle_on   = 1'b1;
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_i      = '0;
    build_cos_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1100);
    test_back_to_back(300);
    wait_drain();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
